### hw/rtl/cpps_pkg.sv
// Shared types, constants and helpers of the convex polygon plane split block.
// No dependencies; the top level convex_polygon_plane_split_core imports this package.
package cpps_pkg;

  localparam int CoordW      = 24;           // Q15.8 coordinates
  localparam int CoefW       = 16;           // Q1.14 normal components
  localparam int OffsW       = 24;           // Q15.8 plane constant
  localparam int EpsW        = 16;
  localparam int CfgAddrW    = 3;
  localparam int CfgDataW    = 24;
  localparam int DistW       = CoordW + 10;  // signed plane distance, Q25.8
  localparam int ProdW       = CoordW + CoefW;
  localparam int AccW        = CoordW + CoefW + 2;
  localparam int MaxVertsDef = 16;
  localparam int MinSide     = 3;

  localparam logic [1:0] SideNone  = 2'd0;
  localparam logic [1:0] SideFront = 2'd1;
  localparam logic [1:0] SideBack  = 2'd2;
  localparam logic [1:0] SideBoth  = 2'd3;

  typedef enum logic [CfgAddrW-1:0] {
    CfgNx     = 3'd0,
    CfgNy     = 3'd1,
    CfgNz     = 3'd2,
    CfgOffset = 3'd3,
    CfgEps    = 3'd4,
    CfgCopl   = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StP1Addr,
    StP1Lat,
    StP1Mac,
    StP1Dist,
    StP1Wrap,
    StP2Init,
    StP2InitL,
    StP2Addr,
    StP2Lat,
    StP2Chk,
    StP2DStart,
    StP2Div,
    StP2XEmit,
    StP2VEmit,
    StFlush
  } state_e;

  typedef struct packed {
    logic signed [CoordW-1:0] vx;
    logic signed [CoordW-1:0] vy;
    logic signed [CoordW-1:0] vz;
    logic                     final_vertex;
  } vtx_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] ox;
    logic signed [CoordW-1:0] oy;
    logic signed [CoordW-1:0] oz;
    logic [1:0]               side_code;
    logic                     run_end;
    logic                     overflow;
  } vtx_out_t;

  function automatic logic [1:0] class_of(input logic signed [DistW-1:0] d,
                                          input logic [EpsW-1:0] eps);
    logic signed [DistW-1:0] pe;
    pe = signed'({{(DistW-EpsW){1'b0}}, eps});
    if (d > pe) begin
      return SideFront;
    end else if (d < -pe) begin
      return SideBack;
    end
    return SideBoth;
  endfunction

  function automatic logic crosses(input logic [1:0] a, input logic [1:0] b);
    return ((a == SideFront) && (b == SideBack)) || ((a == SideBack) && (b == SideFront));
  endfunction

endpackage

### hw/rtl/cpps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cpps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/cpps_muldiv.sv
// Iterative unit: round(a * b / den), half away from zero, on magnitudes.
// Shift-add multiply, one bit a cycle, then restoring divide, one bit a cycle.
module cpps_muldiv #(
  parameter int A_W = 25,
  parameter int B_W = 35,
  parameter int Q_W = 26
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [A_W-1:0] a_i,
  input  logic [B_W-1:0] b_i,
  input  logic [B_W-1:0] den_i,
  output logic           done_o,
  output logic [Q_W-1:0] q_o
);

  localparam int P_W   = A_W + B_W;
  localparam int R_W   = B_W;
  localparam int CNT_W = $clog2(A_W + Q_W + 1);

  logic             busy_q, busy_d;
  logic             div_q, div_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [A_W-1:0]   a_q, a_d;
  logic [B_W-1:0]   b_q, b_d;
  logic [B_W-1:0]   den_q, den_d;
  logic [P_W-1:0]   acc_q, acc_d;
  logic [R_W-1:0]   rem_q, rem_d;
  logic [Q_W-1:0]   sh_q, sh_d;
  logic [P_W-1:0]   num;
  logic [R_W:0]     trial;
  logic             ge;

  always_comb begin
    busy_d = busy_q;
    div_d  = div_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    den_d  = den_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    num    = acc_q + P_W'(den_q >> 1);
    trial  = {rem_q, sh_q[Q_W-1]};
    ge     = (trial >= {1'b0, den_q});
    if (start_i) begin
      busy_d = 1'b1;
      div_d  = 1'b0;
      cnt_d  = CNT_W'(A_W);
      a_d    = a_i;
      b_d    = b_i;
      den_d  = den_i;
      acc_d  = '0;
    end else if (busy_q && !div_q) begin
      if (cnt_q != '0) begin
        acc_d = {acc_q[P_W-2:0], 1'b0} + (a_q[A_W-1] ? P_W'(b_q) : '0);
        a_d   = {a_q[A_W-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
      end else begin
        // add half the divisor, then split into remainder head and quotient bits
        rem_d = R_W'(num >> Q_W);
        sh_d  = num[Q_W-1:0];
        div_d = 1'b1;
        cnt_d = CNT_W'(Q_W);
      end
    end else if (busy_q) begin
      rem_d = ge ? R_W'(trial - {1'b0, den_q}) : trial[R_W-1:0];
      sh_d  = {sh_q[Q_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      div_q  <= div_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    den_q <= den_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign done_o = done_q;
  assign q_o    = sh_q;

endmodule

### hw/rtl/convex_polygon_plane_split_core.sv
// Top level of the convex polygon plane split block.
// Depends on cpps_pkg, cpps_ram (vertex and distance stores) and cpps_muldiv.
//
// Vertices load one per cycle while busy_o is low; the word with final_vertex set
// starts the split and raises busy_o until the last result. The split runs in two
// passes over the vertex store: the first takes, per vertex, one store read and
// its latency state, three multiply-accumulate steps on one 16 x 24 multiplier
// and one classify and write of the distance store; the second reads and checks
// each vertex and, for each edge crossing the plane, interpolates the three
// coordinates in the bit-serial multiply-divide unit and emits the crossing
// point before the vertex. Closing the first pass, fetching the last vertex and
// ending the polygon are states of their own (a coplanar polygon skips the first
// pass and its closing); the last result appears in the first cycle with busy_o
// low. Results appear for a single cycle with result_valid_o and cannot be
// stalled. Write configuration only while busy_o is low.
module convex_polygon_plane_split_core #(
  parameter int MAX_VERTS = cpps_pkg::MaxVertsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  cpps_pkg::vtx_in_t                 in_i,
  output logic                              result_valid_o,
  output cpps_pkg::vtx_out_t                result_o,
  input  logic                              cfg_we_i,
  input  logic [cpps_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [cpps_pkg::CfgDataW-1:0]     cfg_wdata_i
);
  import cpps_pkg::*;

  localparam int AW   = $clog2(MAX_VERTS);
  localparam int CNTW = $clog2(MAX_VERTS + 1);
  localparam int SCW  = $clog2(2 * MAX_VERTS + 1);
  localparam int VW   = 3 * CoordW;
  localparam int MA_W = CoordW + 1;
  localparam int MB_W = DistW + 1;
  localparam int MQ_W = CoordW + 2;

  state_e                   state_q, state_d;
  logic [CNTW-1:0]          cnt_q, cnt_d;
  logic [CNTW-1:0]          k_q, k_d;
  logic                     ovf_q, ovf_d;
  logic [SCW-1:0]           nf_q, nf_d, nb_q, nb_d;
  logic [1:0]               first_cls_q, first_cls_d, prev_cls_q, prev_cls_d;
  logic [1:0]               msel_q, msel_d;
  logic [1:0]               j_q, j_d;
  logic [VW-1:0]            cur_q, cur_d, prev_pt_q, prev_pt_d;
  logic signed [DistW-1:0]  cur_dist_q, cur_dist_d, prev_dist_q, prev_dist_d;
  logic signed [ProdW-1:0]  prod_q, prod_d;
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic [CoordW-1:0]        xpt_q [3];
  logic [CoordW-1:0]        xpt_d [3];
  vtx_out_t                 pend_q, pend_d, out_q, out_d;
  logic                     pend_v_q, pend_v_d, out_v_q, out_v_d;

  logic signed [CoefW-1:0]  nx_q, ny_q, nz_q;
  logic signed [OffsW-1:0]  off_q;
  logic [EpsW-1:0]          eps_q;
  logic                     copl_q;

  logic                     accept, full;
  logic                     v_we, d_we;
  logic [AW-1:0]            rd_addr;
  logic [VW-1:0]            v_rdata;
  logic [DistW-1:0]         d_rdata;
  logic                     md_start, md_done;
  logic [MQ_W-1:0]          md_q;

  logic signed [CoefW-1:0]  coef;
  logic signed [CoordW-1:0] coord, a_c, b_c;
  logic signed [AccW-1:0]   sum, shifted;
  logic signed [DistW-1:0]  dist_new;
  logic [1:0]               cls_new, cls_a, cls_b, keep, tag_b;
  logic                     cross_new;
  logic signed [MA_W-1:0]   diff;
  logic signed [MB_W-1:0]   nd, den;
  logic [MA_W-1:0]          diff_mag;
  logic [MB_W-1:0]          nd_mag, den_mag;
  logic                     md_neg;
  logic                     emit_v;
  vtx_out_t                 emit_w;

  assign busy_o = (state_q != StIdle);
  assign accept = start_i && !busy_o;
  assign full   = (cnt_q == CNTW'(MAX_VERTS));
  assign v_we   = accept && !full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q   <= '0;
      ny_q   <= '0;
      nz_q   <= CoefW'(16384);
      off_q  <= '0;
      eps_q  <= EpsW'(1);
      copl_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgNx:     nx_q   <= cfg_wdata_i[CoefW-1:0];
        CfgNy:     ny_q   <= cfg_wdata_i[CoefW-1:0];
        CfgNz:     nz_q   <= cfg_wdata_i[CoefW-1:0];
        CfgOffset: off_q  <= cfg_wdata_i[OffsW-1:0];
        CfgEps:    eps_q  <= cfg_wdata_i[EpsW-1:0];
        CfgCopl:   copl_q <= cfg_wdata_i[0];
        default:   ;
      endcase
    end
  end

  cpps_ram #(.WIDTH(VW), .DEPTH(MAX_VERTS)) u_vmem (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i ({in_i.vx, in_i.vy, in_i.vz}),
    .raddr_i (rd_addr),
    .rdata_o (v_rdata)
  );

  cpps_ram #(.WIDTH(DistW), .DEPTH(MAX_VERTS)) u_dmem (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (k_q[AW-1:0]),
    .wdata_i (dist_new),
    .raddr_i (rd_addr),
    .rdata_o (d_rdata)
  );

  cpps_muldiv #(.A_W(MA_W), .B_W(MB_W), .Q_W(MQ_W)) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (diff_mag),
    .b_i     (nd_mag),
    .den_i   (den_mag),
    .done_o  (md_done),
    .q_o     (md_q)
  );

  // datapath helpers
  always_comb begin
    unique case (msel_q)
      2'd0:    begin coef = nx_q; coord = cur_q[3*CoordW-1:2*CoordW]; end
      2'd1:    begin coef = ny_q; coord = cur_q[2*CoordW-1:CoordW];   end
      default: begin coef = nz_q; coord = cur_q[CoordW-1:0];          end
    endcase
    unique case (j_q)
      2'd0:    begin
        a_c = prev_pt_q[3*CoordW-1:2*CoordW]; b_c = cur_q[3*CoordW-1:2*CoordW];
      end
      2'd1:    begin
        a_c = prev_pt_q[2*CoordW-1:CoordW];   b_c = cur_q[2*CoordW-1:CoordW];
      end
      default: begin
        a_c = prev_pt_q[CoordW-1:0];          b_c = cur_q[CoordW-1:0];
      end
    endcase
    sum       = acc_q + AccW'(prod_q);
    shifted   = (sum + AccW'(8192)) >>> 14;
    dist_new  = DistW'(shifted) - DistW'(off_q);
    cls_new   = class_of(dist_new, eps_q);
    cross_new = crosses(prev_cls_q, cls_new);
    cls_a     = copl_q ? SideBoth : class_of(prev_dist_q, eps_q);
    cls_b     = copl_q ? SideBoth : class_of(cur_dist_q, eps_q);
    keep      = {(nb_q >= SCW'(MinSide)), (nf_q >= SCW'(MinSide))};
    tag_b     = cls_b & keep;
    diff      = MA_W'(b_c) - MA_W'(a_c);
    nd        = -MB_W'(prev_dist_q);
    den       = MB_W'(cur_dist_q) - MB_W'(prev_dist_q);
    diff_mag  = diff[MA_W-1] ? MA_W'(-diff) : MA_W'(diff);
    nd_mag    = nd[MB_W-1] ? MB_W'(-nd) : MB_W'(nd);
    den_mag   = den[MB_W-1] ? MB_W'(-den) : MB_W'(den);
    md_neg    = diff[MA_W-1] ^ nd[MB_W-1] ^ den[MB_W-1];
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    ovf_d       = ovf_q;
    nf_d        = nf_q;
    nb_d        = nb_q;
    first_cls_d = first_cls_q;
    prev_cls_d  = prev_cls_q;
    msel_d      = msel_q;
    j_d         = j_q;
    cur_d       = cur_q;
    prev_pt_d   = prev_pt_q;
    cur_dist_d  = cur_dist_q;
    prev_dist_d = prev_dist_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    xpt_d       = xpt_q;
    pend_d      = pend_q;
    pend_v_d    = pend_v_q;
    out_d       = out_q;
    out_v_d     = 1'b0;
    rd_addr     = k_q[AW-1:0];
    d_we        = 1'b0;
    md_start    = 1'b0;
    emit_v      = 1'b0;
    emit_w      = '{ox: cur_q[3*CoordW-1:2*CoordW], oy: cur_q[2*CoordW-1:CoordW],
                    oz: cur_q[CoordW-1:0], side_code: tag_b, run_end: 1'b0,
                    overflow: ovf_q};
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
          if (in_i.final_vertex) begin
            k_d = '0;
            if (copl_q) begin
              nf_d    = SCW'(cnt_d);
              nb_d    = SCW'(cnt_d);
              state_d = StP2Init;
            end else begin
              nf_d    = '0;
              nb_d    = '0;
              state_d = StP1Addr;
            end
          end
        end
      end
      StP1Addr: state_d = StP1Lat;
      StP1Lat: begin
        cur_d   = v_rdata;
        msel_d  = 2'd0;
        state_d = StP1Mac;
      end
      StP1Mac: begin
        prod_d = coef * coord;
        acc_d  = (msel_q == 2'd0) ? '0 : sum;
        msel_d = msel_q + 1'b1;
        if (msel_q == 2'd2) begin
          state_d = StP1Dist;
        end
      end
      StP1Dist: begin
        d_we = 1'b1;
        nf_d = nf_q + SCW'(cls_new[0]) + SCW'((k_q != '0) && cross_new);
        nb_d = nb_q + SCW'(cls_new[1]) + SCW'((k_q != '0) && cross_new);
        if (k_q == '0) begin
          first_cls_d = cls_new;
        end
        prev_cls_d = cls_new;
        k_d        = k_q + 1'b1;
        state_d    = (k_d == cnt_q) ? StP1Wrap : StP1Addr;
      end
      StP1Wrap: begin
        // closing edge from the last vertex back to the first
        if (crosses(prev_cls_q, first_cls_q)) begin
          nf_d = nf_q + 1'b1;
          nb_d = nb_q + 1'b1;
        end
        state_d = StP2Init;
      end
      StP2Init: begin
        rd_addr = AW'(cnt_q - 1'b1);
        state_d = StP2InitL;
      end
      StP2InitL: begin
        prev_pt_d   = v_rdata;
        prev_dist_d = d_rdata;
        k_d         = '0;
        state_d     = StP2Addr;
      end
      StP2Addr: state_d = StP2Lat;
      StP2Lat: begin
        cur_d      = v_rdata;
        cur_dist_d = d_rdata;
        state_d    = StP2Chk;
      end
      StP2Chk: begin
        j_d = 2'd0;
        if (!copl_q && crosses(cls_a, cls_b) && (keep != SideNone)) begin
          state_d = StP2DStart;
        end else begin
          state_d = StP2VEmit;
        end
      end
      StP2DStart: begin
        md_start = 1'b1;
        state_d  = StP2Div;
      end
      StP2Div: begin
        if (md_done) begin
          xpt_d[j_q] = CoordW'(a_c) + (md_neg ? -CoordW'(md_q) : CoordW'(md_q));
          j_d        = j_q + 1'b1;
          state_d    = (j_q == 2'd2) ? StP2XEmit : StP2DStart;
        end
      end
      StP2XEmit: begin
        emit_v  = 1'b1;
        emit_w  = '{ox: xpt_q[0], oy: xpt_q[1], oz: xpt_q[2], side_code: keep,
                    run_end: 1'b0, overflow: ovf_q};
        state_d = StP2VEmit;
      end
      StP2VEmit: begin
        emit_v      = (tag_b != SideNone);
        prev_pt_d   = cur_q;
        prev_dist_d = cur_dist_q;
        k_d         = k_q + 1'b1;
        state_d     = (k_d == cnt_q) ? StFlush : StP2Addr;
      end
      StFlush: begin
        out_v_d = 1'b1;
        if (pend_v_q) begin
          out_d         = pend_q;
          out_d.run_end = 1'b1;
        end else begin
          out_d = '{ox: '0, oy: '0, oz: '0, side_code: SideNone, run_end: 1'b1,
                    overflow: ovf_q};
        end
        pend_v_d = 1'b0;
        cnt_d    = '0;
        ovf_d    = 1'b0;
        state_d  = StIdle;
      end
      default: state_d = StIdle;
    endcase
    // hold back one word so the last one can carry run_end
    if (emit_v) begin
      if (pend_v_q) begin
        out_d   = pend_q;
        out_v_d = 1'b1;
      end
      pend_d   = emit_w;
      pend_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      k_q      <= '0;
      ovf_q    <= 1'b0;
      nf_q     <= '0;
      nb_q     <= '0;
      msel_q   <= '0;
      j_q      <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      k_q      <= k_d;
      ovf_q    <= ovf_d;
      nf_q     <= nf_d;
      nb_q     <= nb_d;
      msel_q   <= msel_d;
      j_q      <= j_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_cls_q <= first_cls_d;
    prev_cls_q  <= prev_cls_d;
    cur_q       <= cur_d;
    prev_pt_q   <= prev_pt_d;
    cur_dist_q  <= cur_dist_d;
    prev_dist_q <= prev_dist_d;
    prod_q      <= prod_d;
    acc_q       <= acc_d;
    xpt_q       <= xpt_d;
    pend_q      <= pend_d;
    out_q       <= out_d;
  end

  assign result_valid_o = out_v_q;
  assign result_o       = out_q;

  a_res_only_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result word without a split in progress");

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(MAX_VERTS))
    else $error("vertex count beyond store depth");

  a_term_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.side_code == SideNone)) |-> result_o.run_end)
    else $error("terminator word without run_end");

  a_run_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.run_end) |-> (!busy_o && !pend_v_q))
    else $error("run_end word while split still busy");

endmodule
